// ----- rtl/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

  localparam int DigitCountDefault = 8;
  localparam int SymbolCount = 46;
  localparam int EnableWidth = 8;
  localparam logic [7:0] BlankPattern = 8'hFF;
  localparam logic [7:0] PointBit = 8'h80;

  typedef enum logic [2:0] {
    CMD_SET_SYMBOL = 3'd0,
    CMD_SET_RAW    = 3'd1,
    CMD_SET_POINT  = 3'd2,
    CMD_READ       = 3'd3,
    CMD_CLEAR_ALL  = 3'd4,
    CMD_TICK       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_COMMON_CATHODE = 2'd0,
    CFG_DIGITS_IN_USE  = 2'd1,
    CFG_DIGIT_ON_LEVEL = 2'd2
  } cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_e;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] digit_index;
    logic [5:0] symbol_code;
    logic [7:0] raw_segments;
    logic       point_on;
  } ssd_in_t;

  typedef struct packed {
    logic [7:0] segment_drive;
    logic [7:0] digit_enables;
    logic [7:0] read_pattern;
  } ssd_out_t;

  typedef struct packed {
    logic       pat_we;
    logic       pt_we;
    logic       clear;
    logic       rd_en;
    logic [7:0] pat_wdata;
    logic       pt_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] pattern;
    logic       point;
  } mem_rsp_t;

  function automatic logic [7:0] symbol_lookup(input logic [5:0] code);
    logic [7:0] p;
    case (code)
      6'd0:  p = 8'hC0;
      6'd1:  p = 8'hF9;
      6'd2:  p = 8'hA4;
      6'd3:  p = 8'hB0;
      6'd4:  p = 8'h99;
      6'd5:  p = 8'h92;
      6'd6:  p = 8'h82;
      6'd7:  p = 8'hF8;
      6'd8:  p = 8'h00;
      6'd9:  p = 8'h90;
      6'd10: p = 8'h88;
      6'd11: p = 8'h83;
      6'd12: p = 8'hC6;
      6'd13: p = 8'hA1;
      6'd14: p = 8'h86;
      6'd15: p = 8'h8E;
      6'd16: p = 8'h90;
      6'd17: p = 8'h8B;
      6'd18: p = 8'hCF;
      6'd19: p = 8'hF1;
      6'd20: p = 8'hFF;
      6'd21: p = 8'hF7;
      6'd22: p = 8'hAF;
      6'd23: p = 8'h92;
      6'd24: p = 8'h87;
      6'd25: p = 8'hCE;
      6'd26: p = 8'hC1;
      6'd27: p = 8'hC8;
      6'd28: p = 8'h8C;
      6'd29: p = 8'hE3;
      6'd30: p = 8'h89;
      6'd31: p = 8'hA1;
      6'd32: p = 8'hC7;
      6'd33: p = 8'h80;
      6'd34: p = 8'hFF;
      6'd35: p = 8'h84;
      6'd36: p = 8'hA0;
      6'd37: p = 8'hB6;
      6'd38: p = 8'hFE;
      6'd39: p = 8'hFD;
      6'd40: p = 8'hFB;
      6'd41: p = 8'hF7;
      6'd42: p = 8'hEF;
      6'd43: p = 8'hDF;
      6'd44: p = 8'hBF;
      6'd45: p = 8'h00;
      default: p = BlankPattern;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ssd_store.sv -----
`default_nettype none
module ssd_store
  import ssd_pkg::*;
#(
  parameter int DIGIT_COUNT = DigitCountDefault,
  localparam int AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mem_req_t      req_i,
  input  wire logic [AW-1:0] addr_i,
  output mem_rsp_t           rsp_o
);

  logic [7:0] pat_mem [DIGIT_COUNT];
  logic       pt_mem  [DIGIT_COUNT];

  logic [DIGIT_COUNT-1:0] pat_vld_q, pat_vld_d;
  logic [DIGIT_COUNT-1:0] pt_vld_q, pt_vld_d;
  logic [7:0] pat_rd_q;
  logic       pt_rd_q;
  logic       pat_ok_q, pat_ok_d;
  logic       pt_ok_q, pt_ok_d;

  // pattern and point memories, synchronous read
  always_ff @(posedge clk_i) begin
    if (req_i.pat_we) begin
      pat_mem[addr_i] <= req_i.pat_wdata;
    end
    if (req_i.pt_we) begin
      pt_mem[addr_i] <= req_i.pt_wdata;
    end
    if (req_i.rd_en) begin
      pat_rd_q <= pat_mem[addr_i];
      pt_rd_q  <= pt_mem[addr_i];
    end
  end

  // pattern entries never written since reset or clear read as blank; points never written since reset read as off
  always_comb begin
    pat_vld_d = pat_vld_q;
    pt_vld_d  = pt_vld_q;
    pat_ok_d  = pat_ok_q;
    pt_ok_d   = pt_ok_q;
    if (req_i.clear) begin
      pat_vld_d = '0;
    end
    if (req_i.pat_we) begin
      pat_vld_d[addr_i] = 1'b1;
    end
    if (req_i.pt_we) begin
      pt_vld_d[addr_i] = 1'b1;
    end
    if (req_i.rd_en) begin
      pat_ok_d = pat_vld_q[addr_i];
      pt_ok_d  = pt_vld_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_vld_q <= '0;
      pt_vld_q  <= '0;
      pat_ok_q  <= 1'b0;
      pt_ok_q   <= 1'b0;
    end else begin
      pat_vld_q <= pat_vld_d;
      pt_vld_q  <= pt_vld_d;
      pat_ok_q  <= pat_ok_d;
      pt_ok_q   <= pt_ok_d;
    end
  end

  assign rsp_o.pattern = pat_ok_q ? pat_rd_q : BlankPattern;
  assign rsp_o.point   = pt_ok_q & pt_rd_q;

endmodule
`default_nettype wire

// ----- rtl/ssd_ctrl.sv -----
`default_nettype none
module ssd_ctrl
  import ssd_pkg::*;
#(
  parameter int DIGIT_COUNT = DigitCountDefault,
  localparam int AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ssd_in_t       cmd_i,
  output logic               result_valid_o,
  output ssd_out_t           result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [3:0]    cfg_data_i,
  output mem_req_t           req_o,
  output logic [AW-1:0]      addr_o,
  input  wire mem_rsp_t      rsp_i
);

  localparam int IW = (AW > 3) ? AW : 3;
  localparam int LimInt = (DIGIT_COUNT < EnableWidth) ? DIGIT_COUNT : EnableWidth;
  localparam logic [3:0] Lim = 4'(LimInt);

  st_e state_q, state_d;

  logic       cathode_q, cathode_d;
  logic [3:0] in_use_q, in_use_d;
  logic       on_level_q, on_level_d;

  logic [2:0] scan_q, scan_d;
  logic [2:0] pos_q, pos_d;
  cmd_e       cmd_q, cmd_d;
  logic       ok_q, ok_d;

  logic [7:0] drive_q, drive_d;
  logic [7:0] enable_q, enable_d;
  logic [7:0] readback_q, readback_d;
  logic       done_q, done_d;

  logic       accept;
  cmd_e       cmd_in;
  logic       idx_ok;
  logic [3:0] count;
  logic [2:0] pos_cur;
  logic [3:0] pos_inc;
  logic [IW-1:0] addr_ext;
  logic [7:0] drive_raw;
  logic [7:0] pos_bit;

  assign accept = start && !busy;
  assign cmd_in = cmd_e'(cmd_i.command);
  assign idx_ok = (32'(cmd_i.digit_index) < DIGIT_COUNT);

  always_comb begin
    if (in_use_q == 4'd0) begin
      count = 4'd1;
    end else if (in_use_q > Lim) begin
      count = Lim;
    end else begin
      count = in_use_q;
    end
  end

  assign pos_cur  = ({1'b0, scan_q} >= count) ? 3'd0 : scan_q;
  assign pos_inc  = {1'b0, pos_cur} + 4'd1;
  assign addr_ext = (cmd_in == CMD_TICK) ? IW'(pos_cur) : IW'(cmd_i.digit_index);
  assign addr_o   = addr_ext[AW-1:0];

  // next state
  always_comb begin
    case (state_q)
      ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy  = (state_q == ST_EXEC);
    req_o = '0;
    req_o.pat_wdata = symbol_lookup(cmd_i.symbol_code);
    req_o.pt_wdata  = cmd_i.point_on;
    if (accept) begin
      case (cmd_in)
        CMD_SET_SYMBOL: req_o.pat_we = idx_ok;
        CMD_SET_RAW: begin
          req_o.pat_we    = idx_ok;
          req_o.pat_wdata = ~cmd_i.raw_segments;
        end
        CMD_SET_POINT: req_o.pt_we = idx_ok;
        CMD_READ:      req_o.rd_en = idx_ok;
        CMD_CLEAR_ALL: req_o.clear = 1'b1;
        CMD_TICK:      req_o.rd_en = 1'b1;
        default:       req_o.rd_en = 1'b0;
      endcase
    end
  end

  // transaction capture and scan advance
  always_comb begin
    cmd_d  = cmd_q;
    ok_d   = ok_q;
    pos_d  = pos_q;
    scan_d = scan_q;
    if (accept) begin
      cmd_d = cmd_in;
      ok_d  = idx_ok;
      pos_d = pos_cur;
      if (cmd_in == CMD_TICK) begin
        scan_d = (pos_inc >= count) ? 3'd0 : pos_inc[2:0];
      end
    end
  end

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cathode_d  = cathode_q;
    in_use_d   = in_use_q;
    on_level_d = on_level_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_e'(cfg_index_i))
        CFG_COMMON_CATHODE: cathode_d  = cfg_data_i[0];
        CFG_DIGITS_IN_USE:  in_use_d   = cfg_data_i;
        CFG_DIGIT_ON_LEVEL: on_level_d = cfg_data_i[0];
        default:            in_use_d   = in_use_q;
      endcase
    end
  end

  // result computation from the registered memory read
  always_comb begin
    drive_raw = rsp_i.point ? (rsp_i.pattern & ~PointBit) : (rsp_i.pattern | PointBit);
    pos_bit   = 8'd1 << pos_q;
    drive_d    = drive_q;
    enable_d   = enable_q;
    readback_d = readback_q;
    done_d     = 1'b0;
    if (state_q == ST_EXEC) begin
      done_d     = 1'b1;
      readback_d = (cmd_q == CMD_READ && ok_q) ? rsp_i.pattern : 8'd0;
      if (cmd_q == CMD_TICK) begin
        drive_d  = cathode_q ? ~drive_raw : drive_raw;
        enable_d = on_level_q ? pos_bit : ~pos_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cathode_q  <= 1'b0;
      in_use_q   <= 4'd4;
      on_level_q <= 1'b1;
      scan_q     <= 3'd0;
      pos_q      <= 3'd0;
      cmd_q      <= CMD_SET_SYMBOL;
      ok_q       <= 1'b0;
      drive_q    <= 8'd0;
      enable_q   <= 8'd0;
      readback_q <= 8'd0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cathode_q  <= cathode_d;
      in_use_q   <= in_use_d;
      on_level_q <= on_level_d;
      scan_q     <= scan_d;
      pos_q      <= pos_d;
      cmd_q      <= cmd_d;
      ok_q       <= ok_d;
      drive_q    <= drive_d;
      enable_q   <= enable_d;
      readback_q <= readback_d;
      done_q     <= done_d;
    end
  end

  assign result_valid_o         = done_q;
  assign result_o.segment_drive = drive_q;
  assign result_o.digit_enables = enable_q;
  assign result_o.read_pattern  = readback_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("no execute cycle after accept");

  a_exec_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> result_valid_o) else $error("missing result strobe");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_in == CMD_TICK) |=> ({1'b0, scan_q} < count))
    else $error("scan position past digit count");

endmodule
`default_nettype wire

// ----- rtl/seven_segment_scan_driver_top.sv -----
`default_nettype none
// multiplexed seven-segment scan driver
// command channel: a transaction is accepted on a rising edge with start high
// and busy low; cmd_i carries command, digit index, symbol code, raw segments
// and point state
// every command yields one result on result_o, shown for one cycle with
// result_valid_o high; the receiver cannot stall, so results are never held
// the strobe is high in the cycle after the execute cycle; a command runs
// through its accept cycle and the execute cycle, since the digit memories
// are read through a registered read before the result is formed, and busy
// is high in the execute cycle
// configuration channel: cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i;
// ready is always high; the user writes only while no command is in flight,
// unenforced; tick drives the current digit's segments/enables, advances scan
// reset: all digits blank, points off, scan position 0, drive and enables 0,
// anode polarity, four digits in use, enable level high; no clearing pass
module seven_segment_scan_driver_top
  import ssd_pkg::*;
#(
  parameter int DIGIT_COUNT = DigitCountDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire ssd_in_t    cmd_i,
  output logic            result_valid_o,
  output ssd_out_t        result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [3:0] cfg_data_i
);

  localparam int AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  mem_req_t      req;
  mem_rsp_t      rsp;
  logic [AW-1:0] addr;

  ssd_ctrl #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_o          (req),
    .addr_o         (addr),
    .rsp_i          (rsp)
  );

  ssd_store #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .addr_i (addr),
    .rsp_o  (rsp)
  );

endmodule
`default_nettype wire
